// ===== hw/rtl/bpc_pkg.sv =====
// Shared types, constants and helpers for the pressure compensation pipeline.
package bpc_pkg;

	localparam int DivStages = 32;
	localparam int FrontStages = 11;
	localparam int PostStages = 4;
	localparam int Latency = FrontStages + DivStages + PostStages;

	localparam logic [1:0] RegTemp = 2'd0;
	localparam logic [1:0] RegPressA = 2'd1;
	localparam logic [1:0] RegPressB = 2'd2;
	localparam logic [1:0] RegPressC = 2'd3;

	localparam logic [31:0] TempOffset = 32'd64000;
	localparam logic [31:0] PressBase = 32'd1048576;
	localparam logic [31:0] PressScale = 32'd3125;
	localparam logic [31:0] SignBit = 32'h8000_0000;
	localparam logic [31:0] DivBias = 32'd32768;
	localparam logic [31:0] RoundHalf = 32'd128;

	typedef struct packed {
		logic [31:0] t1, t2, t3;
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	} calib_t;

	typedef struct packed {
		logic [31:0] tc;
		logic [31:0] fine;
		logic        dbl;
		logic        zero;
	} side_t;

	typedef struct packed {
		logic [31:0] num;
		logic [31:0] den;
		side_t       side;
	} div_in_t;

	function automatic logic [31:0] sra(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

// ===== hw/rtl/bpc_front.sv =====
// Temperature path and pressure front end up to the divider operands.
module bpc_front import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  calib_t      cal,
	input  logic        in_v,
	input  logic [19:0] adc_temp,
	input  logic [19:0] adc_press,
	output logic        out_v,
	output div_in_t     out_d
);
	logic [FrontStages-1:0] v_q;
	logic [31:0] x1_s1, d_s1, m1_s2, m2_s2, a_s3, m3_s3, fine_s4;
	logic [31:0] pa_s5, q_s5, tc_s5, qq_s6, ap5_s6, p2a_s6, b6_s7, p3m_s7;
	logic [31:0] b_s8, asum_s8, av_s9, u_s9, a_s10, p_s10;
	logic [31:0] f_s5, f_s6, f_s7, f_s8, f_s9, f_s10;
	logic [31:0] tc_s6, tc_s7, tc_s8, tc_s9, tc_s10;
	logic [31:0] ap5_s7, p2a_s7;
	logic [19:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7, ap_s8;
	logic [31:0] at_w;

	assign at_w = {12'd0, adc_temp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else v_q <= {v_q[FrontStages-2:0], in_v};
	end

	always_ff @(posedge clk) begin
		x1_s1 <= (at_w >> 3) - (cal.t1 << 1);
		d_s1 <= (at_w >> 4) - cal.t1;
		ap_s1 <= adc_press;
		m1_s2 <= x1_s1 * cal.t2;
		m2_s2 <= d_s1 * d_s1;
		ap_s2 <= ap_s1;
		a_s3 <= sra(m1_s2, 11);
		m3_s3 <= sra(m2_s2, 12) * cal.t3;
		ap_s3 <= ap_s2;
		fine_s4 <= a_s3 + sra(m3_s3, 14);
		ap_s4 <= ap_s3;
		// pressure offset, temperature rounding
		pa_s5 <= sra(fine_s4, 1) - TempOffset;
		q_s5 <= sra(sra(fine_s4, 1) - TempOffset, 2);
		tc_s5 <= sra(fine_s4 * 32'd5 + RoundHalf, 8);
		f_s5 <= fine_s4;
		ap_s5 <= ap_s4;
		qq_s6 <= q_s5 * q_s5;
		ap5_s6 <= pa_s5 * cal.p5;
		p2a_s6 <= cal.p2 * pa_s5;
		f_s6 <= f_s5; tc_s6 <= tc_s5; ap_s6 <= ap_s5;
		b6_s7 <= sra(qq_s6, 11) * cal.p6;
		p3m_s7 <= cal.p3 * sra(qq_s6, 13);
		ap5_s7 <= ap5_s6; p2a_s7 <= p2a_s6;
		f_s7 <= f_s6; tc_s7 <= tc_s6; ap_s7 <= ap_s6;
		b_s8 <= sra(b6_s7 + (ap5_s7 << 1), 2) + (cal.p4 << 16);
		asum_s8 <= sra(sra(p3m_s7, 3) + sra(p2a_s7, 1), 18);
		f_s8 <= f_s7; tc_s8 <= tc_s7; ap_s8 <= ap_s7;
		av_s9 <= (DivBias + asum_s8) * cal.p1;
		u_s9 <= (PressBase - {12'd0, ap_s8}) - sra(b_s8, 12);
		f_s9 <= f_s8; tc_s9 <= tc_s8;
		a_s10 <= sra(av_s9, 15);
		p_s10 <= u_s9 * PressScale;
		f_s10 <= f_s9; tc_s10 <= tc_s9;
		// large dividends divide first and double after
		out_d.num <= (p_s10 < SignBit) ? (p_s10 << 1) : p_s10;
		out_d.den <= a_s10;
		out_d.side.dbl <= !(p_s10 < SignBit);
		out_d.side.zero <= (a_s10 == '0);
		out_d.side.tc <= tc_s10;
		out_d.side.fine <= f_s10;
	end

	assign out_v = v_q[FrontStages-1];
endmodule

// ===== hw/rtl/bpc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
module bpc_div import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_v,
	input  div_in_t     in_d,
	output logic        out_v,
	output logic [31:0] quot,
	output side_t       out_side
);
	logic [DivStages-1:0] v_s;
	logic [31:0] rem_s [DivStages];
	logic [31:0] nq_s [DivStages];
	logic [31:0] den_s [DivStages];
	side_t side_s [DivStages];
	logic [31:0] rem_n [DivStages];
	logic [31:0] nq_n [DivStages];

	always_comb begin
		logic [32:0] t;
		logic [31:0] r, n, dv;
		for (int k = 0; k < DivStages; k++) begin
			r = (k == 0) ? 32'd0 : rem_s[(k == 0) ? 0 : k-1];
			n = (k == 0) ? in_d.num : nq_s[(k == 0) ? 0 : k-1];
			dv = (k == 0) ? in_d.den : den_s[(k == 0) ? 0 : k-1];
			t = {r, n[31]};
			if (t >= {1'b0, dv}) begin
				rem_n[k] = 32'(t - {1'b0, dv});
				nq_n[k] = {n[30:0], 1'b1};
			end else begin
				rem_n[k] = t[31:0];
				nq_n[k] = {n[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else v_s <= {v_s[DivStages-2:0], in_v};
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DivStages; k++) begin
			rem_s[k] <= rem_n[k];
			nq_s[k] <= nq_n[k];
			den_s[k] <= (k == 0) ? in_d.den : den_s[(k == 0) ? 0 : k-1];
			side_s[k] <= (k == 0) ? in_d.side : side_s[(k == 0) ? 0 : k-1];
		end
	end

	assign out_v = v_s[DivStages-1];
	assign quot = nq_s[DivStages-1];
	assign out_side = side_s[DivStages-1];
endmodule

// ===== hw/rtl/bpc_post.sv =====
// Final pressure correction after the divider.
module bpc_post import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  calib_t      cal,
	input  logic        in_v,
	input  logic [31:0] quot,
	input  side_t       in_side,
	output logic        done,
	output logic [31:0] temp_centi,
	output logic [31:0] fine_temp,
	output logic [31:0] press_pa,
	output logic        press_valid
);
	logic [PostStages-1:0] v_q;
	logic [31:0] p_s1, p_s2, p_s3, pp_s2, bb_s2, bb_s3, am_s3;
	side_t sd_s1, sd_s2, sd_s3;
	logic [31:0] p3_w, p2_w, corr_w;

	assign p3_w = p_s1 >> 3;
	assign p2_w = p_s1 >> 2;
	assign corr_w = sra(sra(am_s3, 12) + sra(bb_s3, 13) + cal.p7, 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else v_q <= {v_q[PostStages-2:0], in_v};
	end

	always_ff @(posedge clk) begin
		p_s1 <= in_side.dbl ? (quot << 1) : quot;
		sd_s1 <= in_side;
		pp_s2 <= p3_w * p3_w;
		bb_s2 <= p2_w * cal.p8;
		p_s2 <= p_s1; sd_s2 <= sd_s1;
		am_s3 <= cal.p9 * (pp_s2 >> 13);
		bb_s3 <= bb_s2; p_s3 <= p_s2; sd_s3 <= sd_s2;
		temp_centi <= sd_s3.tc;
		fine_temp <= sd_s3.fine;
		press_pa <= sd_s3.zero ? 32'd0 : p_s3 + corr_w;
		press_valid <= !sd_s3.zero;
	end

	assign done = v_q[PostStages-1];
endmodule

// ===== hw/rtl/baro_temp_pressure_compensation_unit.sv =====
// A start transfer passes through the front end, the divider and the post stages to the done strobe.
// Throughput: one reading pair per cycle; busy is always low.
// The divider is a 32-stage pipeline, one quotient bit per stage.
// Reset clears the calibration registers and all stage valid bits.
// Results are shown for one cycle on done; the receiver cannot stall.
module baro_temp_pressure_compensation_unit import bpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [19:0]        adc_temp,
	input  logic [19:0]        adc_press,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [63:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] temp_centi,
	output logic signed [31:0] fine_temp,
	output logic [31:0]        press_pa,
	output logic               press_valid
);
	// calibration words; the user must write them only while the pipeline is empty (not enforced here)
	logic [47:0] temp_cal_q;
	logic [63:0] press_a_q, press_b_q;
	logic [15:0] press_c_q;
	calib_t cal;

	logic front_v, div_v;
	div_in_t front_d;
	logic [31:0] quot;
	side_t div_side;
	logic [31:0] tc_w, fine_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			press_a_q <= '0;
			press_b_q <= '0;
			press_c_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegTemp: temp_cal_q <= cfg_data[47:0];
				RegPressA: press_a_q <= cfg_data;
				RegPressB: press_b_q <= cfg_data;
				RegPressC: press_c_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// unpack into sign- or zero-extended 32-bit words
	always_comb begin
		cal.t1 = {16'd0, temp_cal_q[15:0]};
		cal.t2 = sx16(temp_cal_q[31:16]);
		cal.t3 = sx16(temp_cal_q[47:32]);
		cal.p1 = {16'd0, press_a_q[15:0]};
		cal.p2 = sx16(press_a_q[31:16]);
		cal.p3 = sx16(press_a_q[47:32]);
		cal.p4 = sx16(press_a_q[63:48]);
		cal.p5 = sx16(press_b_q[15:0]);
		cal.p6 = sx16(press_b_q[31:16]);
		cal.p7 = sx16(press_b_q[47:32]);
		cal.p8 = sx16(press_b_q[63:48]);
		cal.p9 = sx16(press_c_q);
	end

	// every cycle can take a transfer
	assign busy = 1'b0;

	bpc_front u_front (
		.clk(clk), .arst_n(arst_n), .cal(cal), .in_v(start && !busy),
		.adc_temp(adc_temp), .adc_press(adc_press),
		.out_v(front_v), .out_d(front_d)
	);

	bpc_div u_div (
		.clk(clk), .arst_n(arst_n), .in_v(front_v), .in_d(front_d),
		.out_v(div_v), .quot(quot), .out_side(div_side)
	);

	bpc_post u_post (
		.clk(clk), .arst_n(arst_n), .cal(cal), .in_v(div_v), .quot(quot),
		.in_side(div_side), .done(done), .temp_centi(tc_w), .fine_temp(fine_w),
		.press_pa(press_pa), .press_valid(press_valid)
	);

	assign temp_centi = $signed(tc_w);
	assign fine_temp = $signed(fine_w);
endmodule

// ===== hw/rtl/bpc_checker.sv =====
// Port-level checks for the compensation unit, bound to the top level.
module bpc_checker import bpc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] press_pa,
	input logic        press_valid
);
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##Latency done)
		else $error("result missing after transfer");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, Latency))
		else $error("result without transfer");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !press_valid |-> press_pa == '0)
		else $error("invalid pressure not zero");
endmodule

bind baro_temp_pressure_compensation_unit bpc_checker u_bpc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.press_pa(press_pa), .press_valid(press_valid)
);

// ===== tb/bpc_scoreboard.sv =====
// Reference predictor and result checker for the pressure compensation unit.
module bpc_scoreboard import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [19:0] adc_temp,
	input  logic [19:0] adc_press,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        done,
	input  logic [31:0] temp_centi,
	input  logic [31:0] fine_temp,
	input  logic [31:0] press_pa,
	input  logic        press_valid,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [31:0] tc;
		logic [31:0] fine;
		logic [31:0] pa;
		logic        ok;
	} reading_t;

	logic [47:0] temp_cal;
	logic [63:0] press_cal_a, press_cal_b;
	logic [15:0] press_cal_c;
	reading_t    readings_due[$];

	function automatic logic [31:0] asr(input logic [31:0] x, input int n);
		logic [31:0] r;
		r = x;
		for (int i = 0; i < n; i++) r = {r[31], r[31:1]};
		return r;
	endfunction

	function automatic logic [31:0] s16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic reading_t compensate(input logic [19:0] at_raw, input logic [19:0] ap_raw);
		logic [31:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] a, b, d, q, p;
		reading_t r;
		at = {12'd0, at_raw};
		ap = {12'd0, ap_raw};
		t1 = {16'd0, temp_cal[15:0]};
		t2 = s16(temp_cal[31:16]);
		t3 = s16(temp_cal[47:32]);
		p1 = {16'd0, press_cal_a[15:0]};
		p2 = s16(press_cal_a[31:16]);
		p3 = s16(press_cal_a[47:32]);
		p4 = s16(press_cal_a[63:48]);
		p5 = s16(press_cal_b[15:0]);
		p6 = s16(press_cal_b[31:16]);
		p7 = s16(press_cal_b[47:32]);
		p8 = s16(press_cal_b[63:48]);
		p9 = s16(press_cal_c);
		// temperature
		a = asr(((at >> 3) - (t1 << 1)) * t2, 11);
		d = (at >> 4) - t1;
		b = asr(asr(d * d, 12) * t3, 14);
		r.fine = a + b;
		r.tc = asr(r.fine * 32'd5 + 32'd128, 8);
		// pressure
		a = asr(r.fine, 1) - 32'd64000;
		q = asr(a, 2);
		b = asr(q * q, 11) * p6;
		b = b + ((a * p5) << 1);
		b = asr(b, 2) + (p4 << 16);
		a = asr(asr(p3 * asr(q * q, 13), 3) + asr(p2 * a, 1), 18);
		a = asr((32'd32768 + a) * p1, 15);
		if (a == 0) begin
			r.pa = 0;
			r.ok = 1'b0;
		end else begin
			p = ((32'd1048576 - ap) - asr(b, 12)) * 32'd3125;
			if (p < 32'h8000_0000) p = (p << 1) / a;
			else p = (p / a) * 32'd2;
			a = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
			b = asr((p >> 2) * p8, 13);
			r.pa = p + asr(a + b + p7, 4);
			r.ok = 1'b1;
		end
		return r;
	endfunction

	assign pending = readings_due.size();

	always @(posedge clk or negedge arst_n) begin
		reading_t exp_r;
		if (!arst_n) begin
			temp_cal <= '0;
			press_cal_a <= '0;
			press_cal_b <= '0;
			press_cal_c <= '0;
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					RegTemp: temp_cal <= cfg_data[47:0];
					RegPressA: press_cal_a <= cfg_data;
					RegPressB: press_cal_b <= cfg_data;
					RegPressC: press_cal_c <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (start && !busy) readings_due.push_back(compensate(adc_temp, adc_press));
			if (done) begin
				if (readings_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, no transfer pending", $time);
				end else begin
					exp_r = readings_due.pop_front();
					if (exp_r.tc !== temp_centi) begin
						errors++;
						$display("%0t: temp_centi exp %0d got %0d", $time,
							$signed(exp_r.tc), $signed(temp_centi));
					end
					if (exp_r.fine !== fine_temp) begin
						errors++;
						$display("%0t: fine_temp exp %0d got %0d", $time,
							$signed(exp_r.fine), $signed(fine_temp));
					end
					if (exp_r.pa !== press_pa) begin
						errors++;
						$display("%0t: press_pa exp %0d got %0d", $time, exp_r.pa, press_pa);
					end
					if (exp_r.ok !== press_valid) begin
						errors++;
						$display("%0t: press_valid exp %0b got %0b", $time,
							exp_r.ok, press_valid);
					end
				end
			end
		end
	end

endmodule

// ===== tb/baro_temp_pressure_compensation_unit_tb.sv =====
// Top level testbench: stimulus, calibration phases, watchdog and verdict.
module baro_temp_pressure_compensation_unit_tb import bpc_pkg::*;;

	logic        clk, arst_n, start, busy, cfg_we, done, press_valid;
	logic [19:0] adc_temp, adc_press;
	logic [1:0]  cfg_idx;
	logic [63:0] cfg_data;
	logic signed [31:0] temp_centi, fine_temp;
	logic [31:0] press_pa;
	int          errors, pending;
	int          quiet_cycles;
	bit          calm;  // no idle gaps while set

	baro_temp_pressure_compensation_unit u_dut (.*);

	bpc_scoreboard u_scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: cycles with no transfer of any kind.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Drives start with the reading and returns once the unit has taken it.
	task automatic send_reading(input logic [19:0] t, input logic [19:0] p);
		logic was_busy;
		while (!calm && $urandom_range(99) < 14) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		adc_temp <= t;
		adc_press <= p;
		forever begin
			was_busy = busy;
			@(posedge clk);
			if (!was_busy) break;
		end
	endtask

	// Calibration is only rewritten once the pipeline has drained.
	task automatic load_calib(input logic [47:0] tcal, input logic [63:0] pa,
		input logic [63:0] pb, input logic [15:0] pc);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= RegTemp;    cfg_data <= {16'hDEAD, tcal}; @(posedge clk);
		cfg_idx <= RegPressA;  cfg_data <= pa;               @(posedge clk);
		cfg_idx <= RegPressB;  cfg_data <= pb;               @(posedge clk);
		cfg_idx <= RegPressC;  cfg_data <= {48'hBEEF_0000_1234, pc}; @(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mix of full-range readings and readings near a typical operating point.
	task automatic random_readings(input int n);
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 3 && i < n / 2);
			if ($urandom_range(1)) send_reading(20'($urandom), 20'($urandom));
			else send_reading(20'(519888 + $urandom_range(40000) - 20000),
				20'(415148 + $urandom_range(80000) - 40000));
		end
		calm = 1'b0;
	endtask

	task automatic directed_readings();
		send_reading(20'd0, 20'd0);
		send_reading(20'hFFFFF, 20'hFFFFF);
		send_reading(20'd0, 20'hFFFFF);
		send_reading(20'hFFFFF, 20'd0);
		send_reading(20'd519888, 20'd415148);
		send_reading(20'hAAAAA, 20'h55555);
		send_reading(20'h55555, 20'hAAAAA);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = RegTemp;
		cfg_data = '0;
		adc_temp = '0;
		adc_press = '0;
		calm = 1'b0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset calibration: P1 is zero, so the divisor is zero and pressure invalid.
		directed_readings();
		random_readings(20);

		// Typical datasheet-like calibration.
		load_calib({16'hFC18, 16'd26435, 16'd27504},
			{16'd2855, 16'd3024, 16'hD643, 16'd36477},
			{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
		directed_readings();
		random_readings(120);

		// All ones: T1 and P1 at maximum, signed words at -1.
		load_calib('1, '1, '1, '1);
		directed_readings();
		random_readings(50);

		// Signed words at their positive and negative extremes.
		load_calib({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
			{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
		directed_readings();
		random_readings(50);

		// Random calibration sets.
		for (int k = 0; k < 4; k++) begin
			load_calib(48'({$urandom, $urandom}), {$urandom, $urandom},
				{$urandom, $urandom}, 16'($urandom));
			random_readings(40);
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
